// ----- rtl/gvg_pkg.sv -----
// Shared types, constants and exp table functions for the Gaussian value and gradient block.
package gvg_pkg;

  localparam int FRAC_BITS = 24;
  localparam int X_W = 32;
  localparam int CEN_W = 32;
  localparam int WID_W = 31;
  localparam int HGT_W = 32;
  localparam int CFG_W = 32;
  localparam int IDX_W = 2;
  localparam int DIST_W = 34;
  localparam int MAG_W = 33;
  localparam int ARG_W = 26;
  localparam int U_W = 28;
  localparam int EX_W = 25;
  localparam int Q_W = 33;
  localparam int QM_W = 32;
  localparam int GNUM_W = 61;
  localparam int SUM_W = 64;
  localparam int LANES = 3;
  localparam int DATA_WIDTH_DEF = 32;
  localparam int EXP_DEPTH_DEF = 256;

  localparam logic [IDX_W-1:0] REG_CENTRE = 2'd0;
  localparam logic [IDX_W-1:0] REG_WIDTH = 2'd1;
  localparam logic [IDX_W-1:0] REG_HEIGHT = 2'd2;
  localparam logic [IDX_W-1:0] REG_WRAP = 2'd3;

  localparam logic [DIST_W-1:0] ONE_Q = DIST_W'(1) << FRAC_BITS;

  typedef struct packed {
    logic [DIST_W-1:0] centre;
    logic [WID_W-1:0]  width;
    logic [HGT_W-1:0]  height;
    logic              on;
  } lane_cfg_t;

  typedef struct packed {
    logic [SUM_W-1:0] tv;
    logic [SUM_W-1:0] tc;
    logic [SUM_W-1:0] tw;
    logic [SUM_W-1:0] th;
  } term_t;

  // exp(-f) in Q31 for f in [0, 1.0], Taylor series
  function automatic logic [63:0] exp_neg_q31(input logic [63:0] f);
    logic [63:0] term;
    logic [63:0] pos;
    logic [63:0] neg;
    term = 64'd1 << 31;
    pos = 64'd1 << 31;
    neg = 64'd0;
    for (int k = 1; k <= 30; k++) begin
      term = ((term * f) >> 31) / 64'(k);
      if (k % 2 == 1) neg = neg + term;
      else pos = pos + term;
    end
    return (pos > neg) ? pos - neg : 64'd0;
  endfunction

  // table entry for exp(-t), t in Q31, result Q24 rounded
  function automatic logic [EX_W-1:0] exp_entry(input logic [63:0] t);
    logic [63:0] e1;
    logic [63:0] v;
    logic [63:0] n;
    e1 = exp_neg_q31(64'd1 << 31);
    n = t >> 31;
    v = exp_neg_q31(t & ((64'd1 << 31) - 64'd1));
    for (int j = 0; j < 17; j++) begin
      if (64'(j) < n) v = (v * e1) >> 31;
    end
    v = (v + 64'd64) >> 7;
    return v[EX_W-1:0];
  endfunction

endpackage

// ----- rtl/gvg_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, with sideband.
module gvg_div #(
  parameter int NUM_W = 26,
  parameter int DEN_W = 31,
  parameter int SIDE_W = 2
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [DEN_W-1:0]  rem_init,
  input  logic [NUM_W-1:0]  num,
  input  logic [SIDE_W-1:0] side_in,
  input  logic [DEN_W-1:0]  den,
  output logic              out_valid,
  output logic [NUM_W-1:0]  quo,
  output logic [SIDE_W-1:0] side_out
);

  logic              vld [NUM_W];
  logic [DEN_W-1:0]  rem [NUM_W];
  logic [NUM_W-1:0]  nq [NUM_W];
  logic [SIDE_W-1:0] side [NUM_W];

  logic              vld_in [NUM_W];
  logic [DEN_W-1:0]  rem_in [NUM_W];
  logic [NUM_W-1:0]  nq_in [NUM_W];
  logic [SIDE_W-1:0] side_src [NUM_W];

  for (genvar i = 0; i < NUM_W; i++) begin : g_stage
    logic [DEN_W:0] trial;
    logic [DEN_W:0] diff;
    logic           ge;

    if (i == 0) begin : g_first
      assign vld_in[i] = in_valid;
      assign rem_in[i] = rem_init;
      assign nq_in[i] = num;
      assign side_src[i] = side_in;
    end else begin : g_next
      assign vld_in[i] = vld[i-1];
      assign rem_in[i] = rem[i-1];
      assign nq_in[i] = nq[i-1];
      assign side_src[i] = side[i-1];
    end

    assign trial = {rem_in[i], nq_in[i][NUM_W-1]};
    assign diff = trial - {1'b0, den};
    assign ge = trial >= {1'b0, den};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else begin
        vld[i] <= vld_in[i];
      end
      rem[i] <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      nq[i] <= {nq_in[i][NUM_W-2:0], ge};
      side[i] <= side_src[i];
    end
  end

  assign out_valid = vld[NUM_W-1];
  assign quo = nq[NUM_W-1];
  assign side_out = side[NUM_W-1];

endmodule

// ----- rtl/gvg_lane.sv -----
// One Gaussian copy: distance, scaled argument, exp lookup and gradient terms.
module gvg_lane #(
  parameter int EXP_TABLE_DEPTH = gvg_pkg::EXP_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic [gvg_pkg::X_W-1:0]     x,
  input  gvg_pkg::lane_cfg_t          cfg,
  output logic                        out_valid,
  output gvg_pkg::term_t              term
);
  import gvg_pkg::*;

  localparam int RI_W = $clog2(EXP_TABLE_DEPTH + 1);
  localparam int POS_W = U_W + RI_W;
  localparam int DP_W = EX_W + FRAC_BITS;
  localparam int HP_W = HGT_W + EX_W + 1;
  localparam logic [DP_W-1:0] DP_HALF = DP_W'(1) << (FRAC_BITS - 1);
  localparam logic [HP_W-1:0] HP_HALF = HP_W'(1) << (FRAC_BITS - 1);

  typedef struct packed {
    logic [ARG_W-1:0] a;
    logic             neg;
    logic             live;
  } carry_t;

  logic [EX_W-1:0] exp_rom [EXP_TABLE_DEPTH+1];

  for (genvar g = 0; g <= EXP_TABLE_DEPTH; g++) begin : g_rom
    localparam logic [63:0] T = (64'(g) << 35) / EXP_TABLE_DEPTH;
    localparam logic [EX_W-1:0] E = exp_entry(T);
    assign exp_rom[g] = E;
  end

  // distance and range check
  logic              s1_vld;
  logic [DIST_W-1:0] s1_dist;
  logic              s2_vld;
  logic [MAG_W-1:0]  s2_md;
  logic              s2_neg;
  logic              s2_live;
  logic [DIST_W-1:0] dist_next;
  logic [DIST_W-1:0] md_full;

  assign dist_next = {{(DIST_W-X_W){x[X_W-1]}}, x} - cfg.centre;
  assign md_full = s1_dist[DIST_W-1] ? DIST_W'(0) - s1_dist : s1_dist;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
      s2_vld <= 1'b0;
    end else begin
      s1_vld <= in_valid;
      s2_vld <= s1_vld;
    end
    s1_dist <= dist_next;
    s2_neg <= s1_dist[DIST_W-1];
    s2_md <= md_full[MAG_W-1:0];
    s2_live <= cfg.on && (md_full[MAG_W-1:0] < {cfg.width, 2'b00});
  end

  // a = |dist| / w in Q24, known below 4.0 when live
  logic             a_vld;
  logic [ARG_W-1:0] a_quo;
  logic [1:0]       a_side;

  gvg_div #(.NUM_W(ARG_W), .DEN_W(WID_W), .SIDE_W(2)) u_div_arg (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s2_vld),
    .rem_init (s2_md[MAG_W-1:2]),
    .num      ({s2_md[1:0], {FRAC_BITS{1'b0}}}),
    .side_in  ({s2_neg, s2_live}),
    .den      (cfg.width),
    .out_valid(a_vld),
    .quo      (a_quo),
    .side_out (a_side)
  );

  logic                s3_vld, s4_vld, s5_vld, s6_vld, s7_vld, s8_vld, s9_vld, s10_vld, s11_vld;
  carry_t              s3_c, s4_c, s5_c, s6_c, s7_c, s8_c, s9_c, s10_c;
  logic [2*ARG_W-1:0]  s3_sq;
  logic [U_W-1:0]      s4_u, s5_u, s6_u, s7_u, s8_u, s9_u, s10_u;
  logic [RI_W-1:0]     s4_idx;
  logic [FRAC_BITS-1:0] s4_fr, s5_fr;
  logic [EX_W-1:0]     s5_e0, s5_e1, s6_e0;
  logic [DP_W-1:0]     s6_dp;
  logic [EX_W-1:0]     s7_ex, s8_ex, s9_ex, s10_ex, s11_ex;
  logic [HP_W-1:0]     s8_hp;
  logic [HP_W-1:0]     s9_mag;
  logic                s9_qneg, s10_qneg;
  logic [QM_W-1:0]     s10_qm;
  logic [QM_W+ARG_W-1:0] s11_pc;
  logic [QM_W+U_W-1:0] s11_pw;
  logic [Q_W-1:0]      s11_q;
  logic                s11_scn, s11_swn, s11_live;

  logic [POS_W-1:0]    pos;
  logic [DP_W-1:0]     dp_rnd;
  logic [HP_W-1:0]     hp_rnd;

  assign pos = POS_W'(s3_sq[2*ARG_W-1:FRAC_BITS]) * POS_W'(EXP_TABLE_DEPTH);
  assign dp_rnd = (s6_dp + DP_HALF) >> FRAC_BITS;
  assign hp_rnd = (s9_mag + HP_HALF) >> FRAC_BITS;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_vld <= 1'b0;
      s4_vld <= 1'b0;
      s5_vld <= 1'b0;
      s6_vld <= 1'b0;
      s7_vld <= 1'b0;
      s8_vld <= 1'b0;
      s9_vld <= 1'b0;
      s10_vld <= 1'b0;
      s11_vld <= 1'b0;
    end else begin
      s3_vld <= a_vld;
      s4_vld <= s3_vld;
      s5_vld <= s4_vld;
      s6_vld <= s5_vld;
      s7_vld <= s6_vld;
      s8_vld <= s7_vld;
      s9_vld <= s8_vld;
      s10_vld <= s9_vld;
      s11_vld <= s10_vld;
    end
    // square
    s3_c <= '{a: a_quo, neg: a_side[1], live: a_side[0]};
    s3_sq <= a_quo * a_quo;
    // table index and fraction
    s4_c <= s3_c;
    s4_u <= s3_sq[2*ARG_W-1:FRAC_BITS];
    s4_idx <= pos[POS_W-1:U_W];
    s4_fr <= pos[U_W-1:U_W-FRAC_BITS];
    // table read
    s5_c <= s4_c;
    s5_u <= s4_u;
    s5_fr <= s4_fr;
    s5_e0 <= exp_rom[s4_idx];
    s5_e1 <= exp_rom[s4_idx + RI_W'(1)];
    // interpolation
    s6_c <= s5_c;
    s6_u <= s5_u;
    s6_e0 <= s5_e0;
    s6_dp <= DP_W'(s5_e0 - s5_e1) * DP_W'(s5_fr);
    s7_c <= s6_c;
    s7_u <= s6_u;
    s7_ex <= s6_e0 - dp_rnd[EX_W-1:0];
    // height product
    s8_c <= s7_c;
    s8_u <= s7_u;
    s8_ex <= s7_ex;
    s8_hp <= HP_W'($signed(cfg.height) * $signed({1'b0, s7_ex}));
    s9_c <= s8_c;
    s9_u <= s8_u;
    s9_ex <= s8_ex;
    s9_qneg <= s8_hp[HP_W-1];
    s9_mag <= s8_hp[HP_W-1] ? HP_W'(0) - s8_hp : s8_hp;
    s10_c <= s9_c;
    s10_u <= s9_u;
    s10_ex <= s9_ex;
    s10_qneg <= s9_qneg;
    s10_qm <= hp_rnd[QM_W-1:0];
    // gradient numerators
    s11_pc <= s10_qm * s10_c.a;
    s11_pw <= s10_qm * s10_u;
    s11_q <= s10_qneg ? Q_W'(0) - {1'b0, s10_qm} : {1'b0, s10_qm};
    s11_scn <= s10_qneg ^ s10_c.neg;
    s11_swn <= s10_qneg;
    s11_live <= s10_c.live;
    s11_ex <= s10_ex;
  end

  logic                c_vld, w_vld;
  logic [GNUM_W-1:0]   c_quo, w_quo;
  logic [Q_W+1:0]      c_side;
  logic [EX_W:0]       w_side;

  gvg_div #(.NUM_W(GNUM_W), .DEN_W(WID_W), .SIDE_W(Q_W+2)) u_div_centre (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s11_vld),
    .rem_init ({WID_W{1'b0}}),
    .num      ({(GNUM_W-1)'(s11_pc), 1'b0}),
    .side_in  ({s11_q, s11_scn, s11_live}),
    .den      (cfg.width),
    .out_valid(c_vld),
    .quo      (c_quo),
    .side_out (c_side)
  );

  gvg_div #(.NUM_W(GNUM_W), .DEN_W(WID_W), .SIDE_W(EX_W+1)) u_div_width (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s11_vld),
    .rem_init ({WID_W{1'b0}}),
    .num      ({s11_pw, 1'b0}),
    .side_in  ({s11_ex, s11_swn}),
    .den      (cfg.width),
    .out_valid(w_vld),
    .quo      (w_quo),
    .side_out (w_side)
  );

  logic [SUM_W-1:0] tc_mag, tw_mag;
  assign tc_mag = SUM_W'(c_quo);
  assign tw_mag = SUM_W'(w_quo);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= c_vld & w_vld;
    end
    if (c_side[0]) begin
      term.tv <= {{(SUM_W-Q_W){c_side[Q_W+1]}}, c_side[Q_W+1:2]};
      term.tc <= c_side[1] ? SUM_W'(0) - tc_mag : tc_mag;
      term.tw <= w_side[0] ? SUM_W'(0) - tw_mag : tw_mag;
      term.th <= SUM_W'(w_side[EX_W:1]);
    end else begin
      term <= '0;
    end
  end

endmodule

// ----- rtl/gaussian_value_and_gradient.sv -----
// Top level: registers, three Gaussian lanes, summation and saturation.
//
// Usage: raise start with sample_x; the item is taken at a clock edge where
// start is high and busy is low. busy is high only during reset, so one item
// may be taken every cycle. Each item gives exactly one result: result_valid
// is high for one cycle with model_value, slope_centre, slope_width and
// slope_height, in the order the items came. The receiver cannot stall;
// results must be captured when the strobe is high. The pipeline holds the
// 26-stage argument divider and the two 61-stage gradient dividers, one
// quotient bit per stage, and takes one item per cycle. Configuration:
// cfg_wr_en, cfg_index, cfg_wr_data write the centre, width, height and
// wrap flag; write them only while no item is in flight. Reset (rst,
// synchronous) clears the pipeline valid bits and restores centre 0, width
// 1.0, height 1.0, wrap off. Items in flight are dropped.
module gaussian_value_and_gradient #(
  parameter int DATA_WIDTH = gvg_pkg::DATA_WIDTH_DEF,
  parameter int EXP_TABLE_DEPTH = gvg_pkg::EXP_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [gvg_pkg::X_W-1:0]     sample_x,
  output logic                        result_valid,
  output logic [DATA_WIDTH-1:0]       model_value,
  output logic [DATA_WIDTH-1:0]       slope_centre,
  output logic [DATA_WIDTH-1:0]       slope_width,
  output logic [DATA_WIDTH-1:0]       slope_height,
  input  logic                        cfg_wr_en,
  input  logic [gvg_pkg::IDX_W-1:0]   cfg_index,
  input  logic [gvg_pkg::CFG_W-1:0]   cfg_wr_data
);
  import gvg_pkg::*;

  localparam int LATENCY = 103;

  function automatic logic [DATA_WIDTH-1:0] sat_out(input logic [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    hi = (SUM_W'(1) << (DATA_WIDTH - 1)) - SUM_W'(1);
    lo = -hi - SUM_W'(1);
    if ($signed(v) > hi) return hi[DATA_WIDTH-1:0];
    if ($signed(v) < lo) return lo[DATA_WIDTH-1:0];
    return v[DATA_WIDTH-1:0];
  endfunction

  logic [CEN_W-1:0] peak_centre;
  logic [WID_W-1:0] peak_width;
  logic [HGT_W-1:0] peak_height;
  logic             wrap_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      peak_centre <= '0;
      peak_width <= WID_W'(1) << FRAC_BITS;
      peak_height <= HGT_W'(1) << FRAC_BITS;
      wrap_mode <= 1'b0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_CENTRE: peak_centre <= cfg_wr_data;
        REG_WIDTH:  peak_width <= cfg_wr_data[WID_W-1:0];
        REG_HEIGHT: peak_height <= cfg_wr_data;
        REG_WRAP:   wrap_mode <= cfg_wr_data[0];
        default:    ;
      endcase
    end
  end

  assign busy = rst;

  logic [WID_W-1:0]  w_eff;
  logic [DIST_W-1:0] c_ext;
  lane_cfg_t         lcfg [LANES];

  assign w_eff = (peak_width == '0) ? WID_W'(1) : peak_width;
  assign c_ext = {{(DIST_W-CEN_W){peak_centre[CEN_W-1]}}, peak_centre};

  assign lcfg[0] = '{centre: c_ext - ONE_Q, width: w_eff, height: peak_height, on: wrap_mode};
  assign lcfg[1] = '{centre: c_ext, width: w_eff, height: peak_height, on: 1'b1};
  assign lcfg[2] = '{centre: c_ext + ONE_Q, width: w_eff, height: peak_height, on: wrap_mode};

  logic             in_vld;
  logic [X_W-1:0]   x_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else begin
      in_vld <= start & ~busy;
    end
    x_r <= sample_x;
  end

  logic  lane_vld [LANES];
  term_t lane_term [LANES];

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    gvg_lane #(.EXP_TABLE_DEPTH(EXP_TABLE_DEPTH)) u_lane (
      .clk      (clk),
      .rst      (rst),
      .in_valid (in_vld),
      .x        (x_r),
      .cfg      (lcfg[l]),
      .out_valid(lane_vld[l]),
      .term     (lane_term[l])
    );
  end

  logic  p_vld, s_vld;
  term_t p_sum, p_last, s_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_vld <= 1'b0;
      s_vld <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      p_vld <= lane_vld[0] & lane_vld[1] & lane_vld[2];
      s_vld <= p_vld;
      result_valid <= s_vld;
    end
    p_sum.tv <= lane_term[0].tv + lane_term[1].tv;
    p_sum.tc <= lane_term[0].tc + lane_term[1].tc;
    p_sum.tw <= lane_term[0].tw + lane_term[1].tw;
    p_sum.th <= lane_term[0].th + lane_term[1].th;
    p_last <= lane_term[2];
    s_sum.tv <= p_sum.tv + p_last.tv;
    s_sum.tc <= p_sum.tc + p_last.tc;
    s_sum.tw <= p_sum.tw + p_last.tw;
    s_sum.th <= p_sum.th + p_last.th;
    model_value <= sat_out(s_sum.tv);
    slope_centre <= sat_out(s_sum.tc);
    slope_width <= sat_out(s_sum.tw);
    slope_height <= sat_out(s_sum.th);
  end

`ifndef SYNTH
  a_result_from_item: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(start & ~busy, LATENCY))
    else $error("result without a matching item");

  a_height_grad_sign: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !slope_height[DATA_WIDTH-1])
    else $error("height gradient negative");
`endif

endmodule
